[design/pclfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclfs_pkg
// Shared types and constants of the LED card frame serializer: item
// structs, configuration register indexes and frame layout.
// ----------------------------------------------------------------------------
package pclfs_pkg;

	// sizes
	localparam int MAX_CARDS_DEF = 8;
	localparam int STACK_TOTAL   = 3;
	localparam int FRAME_BITS    = 48;
	localparam int COLOR_BITS    = 36;
	localparam int POS_W         = 6;
	localparam int SIZE_W        = 5;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 8;

	// frame header: 0x3A followed by the 0xA nibble
	localparam logic [11:0] FRAME_HDR = 12'h3AA;

	// reset value of the gap register
	localparam logic [7:0] GAP_RESET = 8'd16;

	// item kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STACK0_CARDS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STACK1_CARDS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STACK2_CARDS = 8'd3;

	// stack line codes
	localparam logic [1:0] STACK0 = 2'd0;
	localparam logic [1:0] STACK1 = 2'd1;
	localparam logic [1:0] STACK2 = 2'd2;

	// input item
	typedef struct packed {
		logic        req_type;
		logic [1:0]  stack_sel;
		logic [2:0]  card_index;
		logic [11:0] red;
		logic [11:0] green;
		logic [11:0] blue;
	} req_item_t;

	// result item
	typedef struct packed {
		logic [1:0] stack_line;
		logic [1:0] pulse_count;
		logic       card_end;
		logic       stack_end;
	} res_item_t;

	// configuration registers
	typedef struct packed {
		logic [7:0] gap_ticks;
		logic [3:0] stack0_cards;
		logic [3:0] stack1_cards;
		logic [3:0] stack2_cards;
	} cfg_t;

	// per tick info from the sequencer, completed once the color is read
	typedef struct packed {
		logic [1:0]       stack_line;
		logic             bit_tick;
		logic [POS_W-1:0] pos;
		logic             card_end;
		logic             stack_end;
	} tick_info_t;

endpackage

[design/pclfs_card_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclfs_card_mem
// Card color store: one write and one registered read port, with a valid
// bit per entry so that an entry not written since reset reads as zero.
// ----------------------------------------------------------------------------
module pclfs_card_mem #(
	parameter int MAX_CARDS = pclfs_pkg::MAX_CARDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [$clog2(3*MAX_CARDS)-1:0]      wr_addr,
	input  logic [pclfs_pkg::COLOR_BITS-1:0]    wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(3*MAX_CARDS)-1:0]      rd_addr,
	output logic [pclfs_pkg::COLOR_BITS-1:0]    rd_data
);

	localparam int DEPTH = pclfs_pkg::STACK_TOTAL * MAX_CARDS;

	logic [pclfs_pkg::COLOR_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]                 valid_q;
	logic [pclfs_pkg::COLOR_BITS-1:0] rd_data_q;
	logic                             rd_valid_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

[design/pclfs_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclfs_sequencer
// Tick sequencer: walks stacks, cards, frame bits and gaps, and names the
// card whose colour the current tick needs.
// ----------------------------------------------------------------------------
module pclfs_sequencer #(
	parameter int MAX_CARDS = pclfs_pkg::MAX_CARDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick,
	input  pclfs_pkg::cfg_t                   cfg,
	output logic [$clog2(3*MAX_CARDS)-1:0]    rd_addr,
	output pclfs_pkg::tick_info_t             info
);

	localparam int AW = $clog2(3 * MAX_CARDS);
	localparam int IW = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
	localparam int SW = pclfs_pkg::SIZE_W;
	localparam int PW = pclfs_pkg::POS_W;
	localparam logic [PW-1:0] LAST_POS = PW'(pclfs_pkg::FRAME_BITS - 1);

	logic [1:0]    act_q, act_d;
	logic [IW-1:0] sent_q, sent_d;
	logic [PW-1:0] bitpos_q, bitpos_d;
	logic          in_gap_q, in_gap_d;
	logic [7:0]    gap_q, gap_d;
	logic          run_q, run_d;

	logic [3:0]    stk_cards;
	logic [SW-1:0] size;
	logic [PW-1:0] pos;
	logic [SW-1:0] sent_inc;
	logic [8:0]    gap_nx;

	// card count of the active stack, clamped to the store
	always_comb begin
		case (act_q)
			pclfs_pkg::STACK0: stk_cards = cfg.stack0_cards;
			pclfs_pkg::STACK1: stk_cards = cfg.stack1_cards;
			pclfs_pkg::STACK2: stk_cards = cfg.stack2_cards;
			default:           stk_cards = 4'd0;
		endcase
		size = (SW'(stk_cards) > SW'(MAX_CARDS)) ? SW'(MAX_CARDS) : SW'(stk_cards);
	end

	assign pos      = (bitpos_q < PW'(pclfs_pkg::FRAME_BITS)) ? bitpos_q : LAST_POS;
	assign sent_inc = SW'(sent_q) + SW'(1);
	assign gap_nx   = {1'b0, gap_q} + 9'd1;
	assign rd_addr  = AW'(act_q) * AW'(MAX_CARDS) + AW'(sent_q);

	// next state of the walk and the info for this tick
	always_comb begin
		act_d    = act_q;
		sent_d   = sent_q;
		bitpos_d = bitpos_q;
		in_gap_d = in_gap_q;
		gap_d    = gap_q;
		run_d    = run_q;
		info     = '0;
		info.pos = pos;
		if (!run_q) begin
			act_d    = (act_q < pclfs_pkg::STACK2) ? act_q + 2'd1 : pclfs_pkg::STACK0;
			sent_d   = '0;
			bitpos_d = '0;
			in_gap_d = 1'b0;
			gap_d    = '0;
			run_d    = 1'b1;
		end else if (size == '0) begin
			run_d          = 1'b0;
			info.stack_end = 1'b1;
		end else if (!in_gap_q) begin
			info.bit_tick = 1'b1;
			bitpos_d      = pos + PW'(1);
			if (pos == LAST_POS) begin
				info.card_end = 1'b1;
				if (sent_inc < size) begin
					sent_d   = sent_q + IW'(1);
					in_gap_d = 1'b1;
					gap_d    = '0;
				end else begin
					run_d          = 1'b0;
					info.stack_end = 1'b1;
				end
			end
		end else begin
			gap_d = gap_nx[7:0];
			if (gap_nx > {1'b0, cfg.gap_ticks}) begin
				in_gap_d = 1'b0;
				bitpos_d = '0;
			end
		end
		info.stack_line = act_d;
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= pclfs_pkg::STACK0;
			sent_q   <= '0;
			bitpos_q <= '0;
			in_gap_q <= 1'b0;
			gap_q    <= '0;
			run_q    <= 1'b1;
		end else if (tick) begin
			act_q    <= act_d;
			sent_q   <= sent_d;
			bitpos_q <= bitpos_d;
			in_gap_q <= in_gap_d;
			gap_q    <= gap_d;
			run_q    <= run_d;
		end
	end

endmodule

[design/pulse_count_led_frame_serializer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_count_led_frame_serializer_core
// Three-stack LED card frame serializer with a card color store.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req): a write item stores the color
//   of one card and gives no result; a tick item gives exactly one result on
//   the res channel (res_valid / res_stall / res) naming the stack line, the
//   pulse count of the bit and the card and stack end marks.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the gap
//   length and the card count of each stack; cfg_ready is always high. The
//   user must write while the block is idle; the block does not enforce it.
//   The accepting edge loads the color read and the tick info into stage
//   one, and stage one loads the output register once that is free, raising
//   res_valid. Throughput: one item per cycle while req_stall is low, set by
//   the single read and single write port of the color store.
//   Reset clears every card color to zero (per entry valid bits, no sweep),
//   the walk restarts on stack zero and the gap register returns to 16.
//   When the receiver stalls, the output register holds its result and one
//   more tick result waits behind it; with both full, req_stall rises.
// ----------------------------------------------------------------------------
module pulse_count_led_frame_serializer_core #(
	parameter int MAX_CARDS = pclfs_pkg::MAX_CARDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  pclfs_pkg::req_item_t                req,
	output logic                                res_valid,
	input  logic                                res_stall,
	output pclfs_pkg::res_item_t                res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pclfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pclfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(3 * MAX_CARDS);
	localparam int FB = pclfs_pkg::FRAME_BITS;
	localparam int PW = pclfs_pkg::POS_W;

	pclfs_pkg::cfg_t       cfg_q;
	pclfs_pkg::tick_info_t info, info_s1;
	pclfs_pkg::res_item_t  res_q;

	logic                             accept, tick_acc, wr_en;
	logic [AW-1:0]                    wr_addr, rd_addr;
	logic [pclfs_pkg::COLOR_BITS-1:0] rd_data;
	logic                             s1_valid_q, res_valid_q;
	logic                             s2_free, s1_adv;
	logic [FB-1:0]                    frame;
	logic [PW-1:0]                    bit_idx;
	logic                             frame_bit;
	logic [1:0]                       pulses;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks    <= pclfs_pkg::GAP_RESET;
			cfg_q.stack0_cards <= 4'd0;
			cfg_q.stack1_cards <= 4'd0;
			cfg_q.stack2_cards <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pclfs_pkg::CFG_GAP_TICKS:    cfg_q.gap_ticks    <= cfg_data;
				pclfs_pkg::CFG_STACK0_CARDS: cfg_q.stack0_cards <= cfg_data[3:0];
				pclfs_pkg::CFG_STACK1_CARDS: cfg_q.stack1_cards <= cfg_data[3:0];
				pclfs_pkg::CFG_STACK2_CARDS: cfg_q.stack2_cards <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// handshake and flow control
	assign s2_free   = !res_valid_q || !res_stall;
	assign s1_adv    = s1_valid_q && s2_free;
	assign req_stall = s1_valid_q && !s2_free;
	assign accept    = req_valid && !req_stall;
	assign tick_acc  = accept && (req.req_type == pclfs_pkg::REQ_TICK);

	// write decode: stack three and cards past the store are dropped
	assign wr_en = accept && (req.req_type == pclfs_pkg::REQ_WRITE)
		&& (req.stack_sel < 2'(pclfs_pkg::STACK_TOTAL))
		&& (5'(req.card_index) < 5'(MAX_CARDS));
	assign wr_addr = AW'(req.stack_sel) * AW'(MAX_CARDS) + AW'(req.card_index);

	pclfs_card_mem #(
		.MAX_CARDS (MAX_CARDS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({req.red, req.green, req.blue}),
		.rd_en   (tick_acc),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pclfs_sequencer #(
		.MAX_CARDS (MAX_CARDS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_acc),
		.cfg     (cfg_q),
		.rd_addr (rd_addr),
		.info    (info)
	);

	// stage one: tick info waits for the color read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (tick_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			info_s1 <= info;
		end
	end

	// pick the frame bit, most significant first
	assign frame     = {pclfs_pkg::FRAME_HDR, rd_data};
	assign bit_idx   = PW'(FB - 1) - info_s1.pos;
	assign frame_bit = frame[bit_idx];
	assign pulses    = info_s1.bit_tick ? (frame_bit ? 2'd2 : 2'd1) : 2'd0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q.stack_line  <= info_s1.stack_line;
			res_q.pulse_count <= pulses;
			res_q.card_end    <= info_s1.card_end;
			res_q.stack_end   <= info_s1.stack_end;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	a_tick_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> s1_valid_q)
		else $error("accepted tick did not reach stage one");

	a_write_no_result : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == pclfs_pkg::REQ_WRITE) && !s1_valid_q) |=> !s1_valid_q)
		else $error("write item produced a result");

	a_card_end_has_pulse : assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.card_end) |-> (res.pulse_count != 2'd0))
		else $error("card end on a quiet tick");

	a_pulse_range : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.pulse_count != 2'd3))
		else $error("pulse count out of range");

endmodule

[tb/tb_pulse_count_led_frame_serializer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_count_led_frame_serializer_core
// Self-checking bench for the LED card frame serializer. A cycle-level
// predictor mirrors the color store, the stack walk and the gap counter,
// queues one expected result per tick item and compares every result field
// by field. Directed items cover color extremes, ignored writes and the
// empty-stack rotation. Random phases then run under several gap and
// card-count settings, with random idling, a long receiver hold-off and a
// sender pause.
// ----------------------------------------------------------------------------
module tb_pulse_count_led_frame_serializer_core;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 80;
	localparam int SETTLE_CYCLES  = 4;
	localparam int REPORT_LIMIT   = 10;

	localparam int MAXC = pclfs_pkg::MAX_CARDS_DEF;
	localparam int FBIT = pclfs_pkg::FRAME_BITS;

	localparam logic [1:0] PULSES_QUIET = 2'd0;
	localparam logic [1:0] PULSES_ZERO  = 2'd1;
	localparam logic [1:0] PULSES_ONE   = 2'd2;
	localparam logic [1:0] STACK_NONE   = 2'd3;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             req_valid = 1'b0;
	logic                             req_stall;
	pclfs_pkg::req_item_t             req       = '0;
	logic                             res_valid;
	logic                             res_stall = 1'b0;
	pclfs_pkg::res_item_t             res;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [pclfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pclfs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// idling knobs in percent, per item for the sender and per cycle for the receiver
	int gap_pct   = 0;
	int stall_pct = 0;
	int holds_asked = 0;
	int holds_taken = 0;
	int hold_left   = 0;

	// mirror of the block
	logic [pclfs_pkg::COLOR_BITS-1:0] card_rgb [pclfs_pkg::STACK_TOTAL*MAXC];
	logic [7:0]                       gap_cfg;
	logic [3:0]                       cards_cfg [pclfs_pkg::STACK_TOTAL];
	logic [1:0]                       cur_stack;
	logic [3:0]                       cards_done;
	int unsigned                      bit_pos;
	logic                             in_quiet;
	logic [7:0]                       quiet_cnt;
	logic                             walking;
	pclfs_pkg::res_item_t             pending_pulses [$];

	int mismatches = 0;
	int n_ticks = 0;
	int n_writes = 0;
	int n_results = 0;
	int n_card_ends = 0;
	int n_stack_ends = 0;
	int idle_cycles = 0;

	pulse_count_led_frame_serializer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// mirror state after reset
	function automatic void clear_mirror();
		foreach (card_rgb[i]) card_rgb[i] = '0;
		foreach (cards_cfg[i]) cards_cfg[i] = '0;
		gap_cfg    = pclfs_pkg::GAP_RESET;
		cur_stack  = pclfs_pkg::STACK0;
		cards_done = '0;
		bit_pos    = 0;
		in_quiet   = 1'b0;
		quiet_cnt  = '0;
		walking    = 1'b1;
		pending_pulses.delete();
	endfunction

	function automatic void apply_cfg(input logic [pclfs_pkg::CFG_IDX_W-1:0] idx,
			input logic [pclfs_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			pclfs_pkg::CFG_GAP_TICKS:    gap_cfg = val;
			pclfs_pkg::CFG_STACK0_CARDS: cards_cfg[pclfs_pkg::STACK0] = val[3:0];
			pclfs_pkg::CFG_STACK1_CARDS: cards_cfg[pclfs_pkg::STACK1] = val[3:0];
			pclfs_pkg::CFG_STACK2_CARDS: cards_cfg[pclfs_pkg::STACK2] = val[3:0];
			default: ;
		endcase
	endfunction

	function automatic void store_color(input pclfs_pkg::req_item_t item);
		if (item.stack_sel < pclfs_pkg::STACK_TOTAL && item.card_index < MAXC)
			card_rgb[item.stack_sel*MAXC + item.card_index] =
				{item.red, item.green, item.blue};
	endfunction

	// one tick of the stack walk: returns the pulses sent on this tick
	function automatic pclfs_pkg::res_item_t advance_walk();
		pclfs_pkg::res_item_t             r;
		int unsigned                      size;
		int unsigned                      pos;
		int unsigned                      next;
		logic [pclfs_pkg::COLOR_BITS-1:0] color;
		logic [FBIT-1:0]                  frame;
		r = '0;
		r.pulse_count = PULSES_QUIET;
		if (!walking) begin
			// switch tick: move on to the next stack
			cur_stack  = (cur_stack == pclfs_pkg::STACK2) ? pclfs_pkg::STACK0
				: cur_stack + 2'd1;
			cards_done = '0;
			bit_pos    = 0;
			in_quiet   = 1'b0;
			quiet_cnt  = '0;
			walking    = 1'b1;
		end else begin
			size = (cards_cfg[cur_stack] > MAXC) ? MAXC : cards_cfg[cur_stack];
			if (size == 0) begin
				walking     = 1'b0;
				r.stack_end = 1'b1;
			end else if (!in_quiet) begin
				color = (cards_done < MAXC) ? card_rgb[cur_stack*MAXC + cards_done] : '0;
				frame = {pclfs_pkg::FRAME_HDR, color};
				pos   = (bit_pos < FBIT) ? bit_pos : FBIT - 1;
				r.pulse_count = frame[FBIT-1-pos] ? PULSES_ONE : PULSES_ZERO;
				bit_pos = pos + 1;
				if (bit_pos >= FBIT) begin
					r.card_end = 1'b1;
					if (int'(cards_done) + 1 < size) begin
						cards_done = cards_done + 4'd1;
						in_quiet   = 1'b1;
						quiet_cnt  = '0;
					end else begin
						cards_done  = cards_done + 4'd1;
						walking     = 1'b0;
						r.stack_end = 1'b1;
					end
				end
			end else begin
				next      = int'(quiet_cnt) + 1;
				quiet_cnt = quiet_cnt + 8'd1;
				if (next > gap_cfg) begin
					in_quiet = 1'b0;
					bit_pos  = 0;
				end
			end
		end
		r.stack_line = cur_stack;
		return r;
	endfunction

	// check results, then predict from accepted items
	always @(posedge clk) begin
		pclfs_pkg::res_item_t want;
		if (!arst_n) begin
			clear_mirror();
		end else begin
			if (cfg_valid && cfg_ready)
				apply_cfg(cfg_index, cfg_data);
			if (res_valid && !res_stall) begin
				n_results++;
				if (pending_pulses.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected result line %0d pulses %0d ", $time,
							res.stack_line, res.pulse_count, "card_end %b stack_end %b",
							res.card_end, res.stack_end);
					mismatches++;
				end else begin
					want = pending_pulses.pop_front();
					if (res.stack_line !== want.stack_line ||
							res.pulse_count !== want.pulse_count ||
							res.card_end !== want.card_end ||
							res.stack_end !== want.stack_end) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: mismatch expected line %0d pulses %0d ", $time,
								want.stack_line, want.pulse_count,
								"card_end %b stack_end %b, ", want.card_end, want.stack_end,
								"got line %0d pulses %0d ", res.stack_line, res.pulse_count,
								"card_end %b stack_end %b", res.card_end, res.stack_end);
						mismatches++;
					end
					if (want.card_end) n_card_ends++;
					if (want.stack_end) n_stack_ends++;
				end
			end
			if (req_valid && !req_stall) begin
				if (req.req_type == pclfs_pkg::REQ_WRITE) begin
					n_writes++;
					store_color(req);
				end else begin
					n_ticks++;
					pending_pulses.push_back(advance_walk());
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_taken != holds_asked) begin
			res_stall   <= 1'b1;
			hold_left   <= LONG_HOLD - 1;
			holds_taken <= holds_taken + 1;
		end else if ($urandom_range(99) < stall_pct) begin
			res_stall <= 1'b1;
			hold_left <= ($urandom_range(15) == 0) ? $urandom_range(25, 8) : $urandom_range(2, 0);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic logic [11:0] rand_level();
		case ($urandom_range(7))
			0: return 12'h000;
			1: return 12'hFFF;
			default: return 12'($urandom_range(4095));
		endcase
	endfunction

	function automatic pclfs_pkg::req_item_t make_write(input logic [1:0] stack,
			input logic [2:0] card, input logic [11:0] r, input logic [11:0] g,
			input logic [11:0] b);
		pclfs_pkg::req_item_t item;
		item.req_type   = pclfs_pkg::REQ_WRITE;
		item.stack_sel  = stack;
		item.card_index = card;
		item.red        = r;
		item.green      = g;
		item.blue       = b;
		return item;
	endfunction

	// tick items carry random filler in the color fields
	function automatic pclfs_pkg::req_item_t make_tick();
		pclfs_pkg::req_item_t item;
		item = make_write(2'($urandom_range(3)), 3'($urandom_range(7)), rand_level(),
			rand_level(), rand_level());
		item.req_type = pclfs_pkg::REQ_TICK;
		return item;
	endfunction

	task automatic send_item(input pclfs_pkg::req_item_t item);
		int idle;
		idle = 0;
		if ($urandom_range(99) < gap_pct)
			idle = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
		if (idle != 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// stop offering items and let every expected result come back
	task automatic wait_drain();
		req_valid <= 1'b0;
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [pclfs_pkg::CFG_IDX_W-1:0] idx,
			input logic [pclfs_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] gap, input logic [3:0] c0,
			input logic [3:0] c1, input logic [3:0] c2);
		wait_drain();
		cfg_write(pclfs_pkg::CFG_GAP_TICKS, gap);
		cfg_write(pclfs_pkg::CFG_STACK0_CARDS, {4'd0, c0});
		cfg_write(pclfs_pkg::CFG_STACK1_CARDS, {4'd0, c1});
		cfg_write(pclfs_pkg::CFG_STACK2_CARDS, {4'd0, c2});
		cfg_valid <= 1'b0;
	endtask

	// mostly ticks, some color writes to any stack including the unused one
	task automatic run_mix(input int count, input int write_pct);
		repeat (count) begin
			if ($urandom_range(99) < write_pct)
				send_item(make_write(2'($urandom_range(3)), 3'($urandom_range(7)),
					rand_level(), rand_level(), rand_level()));
			else
				send_item(make_tick());
		end
	endtask

	// color extremes, last card index and writes to the missing stack
	task automatic test_color_writes();
		gap_pct   = 0;
		stall_pct = 0;
		send_item(make_write(pclfs_pkg::STACK0, 3'd0, 12'hFFF, 12'hFFF, 12'hFFF));
		send_item(make_write(pclfs_pkg::STACK0, 3'd1, 12'h000, 12'h000, 12'h000));
		send_item(make_write(pclfs_pkg::STACK1, 3'd7, 12'hAAA, 12'h555, 12'h800));
		send_item(make_write(pclfs_pkg::STACK2, 3'd0, 12'h001, 12'h7FF, 12'hFFE));
		send_item(make_write(pclfs_pkg::STACK2, 3'd7, rand_level(), rand_level(),
			rand_level()));
		send_item(make_write(STACK_NONE, 3'd0, 12'hFFF, 12'hFFF, 12'hFFF));
		send_item(make_write(STACK_NONE, 3'd7, 12'h123, 12'h456, 12'h789));
	endtask

	// all stacks empty after reset: stack end and switch ticks alternate
	task automatic test_empty_stacks();
		repeat (7) send_item(make_tick());
		wait_drain();
	endtask

	// shortest gap, one card, two cards and a full stack
	task automatic test_short_gaps();
		set_config(8'd0, 4'd1, 4'd2, 4'd8);
		gap_pct   = 20;
		stall_pct = 20;
		run_mix(150, 15);
	endtask

	// longest gap between the two cards of stack zero
	task automatic test_longest_gap();
		set_config(8'd255, 4'd2, 4'd0, 4'd0);
		gap_pct   = 5;
		stall_pct = 10;
		run_mix(400, 2);
	endtask

	// oversized stacks while the receiver holds off and the input backs up
	task automatic test_backpressure();
		set_config(8'd3, 4'd15, 4'd0, 4'd9);
		gap_pct = 0;
		holds_asked++;
		run_mix(50, 0);
		gap_pct   = 20;
		stall_pct = 20;
		run_mix(80, 10);
	endtask

	// sender stops until every result is back, then resumes mid stack
	task automatic test_sender_pause();
		run_mix(30, 10);
		wait_drain();
		run_mix(30, 10);
	endtask

	// random settings, first with no idling at all, then with idling
	task automatic test_random_settings();
		set_config(8'($urandom_range(20)), 4'($urandom_range(15)), 4'($urandom_range(15)),
			4'($urandom_range(15)));
		gap_pct   = 0;
		stall_pct = 0;
		run_mix(80, 10);
		set_config(8'($urandom_range(40)), 4'($urandom_range(15)), 4'($urandom_range(15)),
			4'($urandom_range(15)));
		gap_pct   = 25;
		stall_pct = 25;
		run_mix(60, 20);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_color_writes();
		test_empty_stacks();
		test_short_gaps();
		test_longest_gap();
		test_backpressure();
		test_sender_pause();
		test_random_settings();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d ticks and %0d color writes under several gap and card settings",
			n_ticks, n_writes);
		$display("%0d results checked: %0d card ends, %0d stack ends, %0d mismatches",
			n_results, n_card_ends, n_stack_ends, mismatches);
		if (mismatches == 0 && pending_pulses.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
